/* hdl/kft_pkg.sv */
// Package: widths, config indices, opcodes, command/status types and controller states for the Kalman filter
package kft_pkg;

    localparam int DATA_W_DEF = 32;
    localparam int FRAC_DEF   = 16;
    localparam int REG_W      = 32;
    localparam int VAR_W      = 31;
    localparam int IDX_W      = 3;

    localparam logic [IDX_W-1:0] IDX_T00  = 3'd0;
    localparam logic [IDX_W-1:0] IDX_T01  = 3'd1;
    localparam logic [IDX_W-1:0] IDX_T10  = 3'd2;
    localparam logic [IDX_W-1:0] IDX_T11  = 3'd3;
    localparam logic [IDX_W-1:0] IDX_H0   = 3'd4;
    localparam logic [IDX_W-1:0] IDX_H1   = 3'd5;
    localparam logic [IDX_W-1:0] IDX_R    = 3'd6;
    localparam logic [IDX_W-1:0] IDX_INIT = 3'd7;

    // register file slots of the datapath
    typedef enum logic [4:0] {
        RS_X0, RS_X1, RS_P00, RS_P01, RS_P10, RS_P11,
        RS_Z, RS_Y, RS_PH0, RS_PH1, RS_S, RS_K0, RS_K1, RS_HP0, RS_HP1,
        RS_A00, RS_A01, RS_A10, RS_A11, RS_ACC,
        RS_F00, RS_F01, RS_F10, RS_F11, RS_H0, RS_H1, RS_R, RS_ZERO
    } slot_t;

    // accumulate operation
    typedef enum logic [1:0] {
        AC_LOAD, AC_ADD, AC_SUB
    } acc_op_t;

    typedef struct packed {
        logic    load;      // take input transaction
        logic    restart;
        logic    mul_go;    // acc (op)= a*b
        slot_t   mul_a;
        slot_t   mul_b;
        acc_op_t op;
        logic    add_go;    // acc (op)= a  (no multiply)
        logic    store;     // slot := acc
        slot_t   dst;
        logic    div_go;    // start divider: a / S
        slot_t   div_num;
        logic    div_store;
        slot_t   div_dst;
        logic    chk_s;
        logic    publish;
    } cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
        logic degen;
    } stat_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RUN, ST_WAIT, ST_DIV, ST_OUT
    } state_t;

endpackage

/* hdl/kft_datapath.sv */
// Datapath: register file, shared multiplier/accumulator and serial divider
module kft_datapath
    import kft_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_W_DEF,
    parameter int FRAC_BITS  = FRAC_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cmd_t                         cmd,
    output stat_t                        stat,
    input  logic signed [DATA_WIDTH-1:0] measurement,
    input  logic signed [REG_W-1:0]      f00,
    input  logic signed [REG_W-1:0]      f01,
    input  logic signed [REG_W-1:0]      f10,
    input  logic signed [REG_W-1:0]      f11,
    input  logic signed [REG_W-1:0]      h0,
    input  logic signed [REG_W-1:0]      h1,
    input  logic        [VAR_W-1:0]      r_var,
    input  logic        [VAR_W-1:0]      init_var,
    output logic signed [DATA_WIDTH-1:0] position,
    output logic signed [DATA_WIDTH-1:0] velocity,
    output logic signed [DATA_WIDTH-1:0] cov_00,
    output logic signed [DATA_WIDTH-1:0] cov_01,
    output logic signed [DATA_WIDTH-1:0] cov_10,
    output logic signed [DATA_WIDTH-1:0] cov_11,
    output logic                         degenerate,
    output logic                         saturated
);
    localparam int D  = DATA_WIDTH;
    localparam int W  = (D > REG_W) ? D : REG_W;   // operand width
    localparam int PW = 2 * W;
    localparam int EW = PW + 2;
    localparam int NW = D + FRAC_BITS + 1;         // divider numerator
    localparam int CW = $clog2(NW + 1);
    localparam logic signed [EW-1:0] HI = EW'((PW'(1) <<< (D - 1)) - 1);
    localparam logic signed [EW-1:0] LO = -HI - EW'(1);

    logic signed [D-1:0] x0_reg, x1_reg, p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [D-1:0] z_reg, y_reg, ph0_reg, ph1_reg, s_reg, k0_reg, k1_reg;
    logic signed [D-1:0] hp0_reg, hp1_reg, a00_reg, a01_reg, a10_reg, a11_reg;
    logic signed [D-1:0] acc_reg;
    logic signed [EW-1:0] accw_reg;                // exact sum, clipped on store
    logic                sat_reg, degen_reg;

    function automatic logic signed [W-1:0] rd(input slot_t s,
        input logic signed [D-1:0] x0, x1, p00, p01, p10, p11, z, y, ph0, ph1,
        sv, k0, k1, hp0, hp1, a00, a01, a10, a11, acc,
        input logic signed [REG_W-1:0] ff00, ff01, ff10, ff11, hh0, hh1,
        input logic [VAR_W-1:0] rr);
        logic signed [W-1:0] v;
        begin
            case (s)
                RS_X0:   v = W'(x0);
                RS_X1:   v = W'(x1);
                RS_P00:  v = W'(p00);
                RS_P01:  v = W'(p01);
                RS_P10:  v = W'(p10);
                RS_P11:  v = W'(p11);
                RS_Z:    v = W'(z);
                RS_Y:    v = W'(y);
                RS_PH0:  v = W'(ph0);
                RS_PH1:  v = W'(ph1);
                RS_S:    v = W'(sv);
                RS_K0:   v = W'(k0);
                RS_K1:   v = W'(k1);
                RS_HP0:  v = W'(hp0);
                RS_HP1:  v = W'(hp1);
                RS_A00:  v = W'(a00);
                RS_A01:  v = W'(a01);
                RS_A10:  v = W'(a10);
                RS_A11:  v = W'(a11);
                RS_ACC:  v = W'(acc);
                RS_F00:  v = W'(ff00);
                RS_F01:  v = W'(ff01);
                RS_F10:  v = W'(ff10);
                RS_F11:  v = W'(ff11);
                RS_H0:   v = W'(hh0);
                RS_H1:   v = W'(hh1);
                RS_R:    v = W'(signed'({1'b0, rr}));
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    logic signed [W-1:0] op_a, op_b, op_n;
    always_comb
    begin
        op_a = rd(cmd.mul_a, x0_reg, x1_reg, p00_reg, p01_reg, p10_reg, p11_reg, z_reg,
            y_reg, ph0_reg, ph1_reg, s_reg, k0_reg, k1_reg, hp0_reg, hp1_reg, a00_reg,
            a01_reg, a10_reg, a11_reg, acc_reg, f00, f01, f10, f11, h0, h1, r_var);
        op_b = rd(cmd.mul_b, x0_reg, x1_reg, p00_reg, p01_reg, p10_reg, p11_reg, z_reg,
            y_reg, ph0_reg, ph1_reg, s_reg, k0_reg, k1_reg, hp0_reg, hp1_reg, a00_reg,
            a01_reg, a10_reg, a11_reg, acc_reg, f00, f01, f10, f11, h0, h1, r_var);
        op_n = rd(cmd.div_num, x0_reg, x1_reg, p00_reg, p01_reg, p10_reg, p11_reg, z_reg,
            y_reg, ph0_reg, ph1_reg, s_reg, k0_reg, k1_reg, hp0_reg, hp1_reg, a00_reg,
            a01_reg, a10_reg, a11_reg, acc_reg, f00, f01, f10, f11, h0, h1, r_var);
    end

    // multiplier stage 1: registered product; stage 2: round, saturate, accumulate
    logic signed [PW-1:0] prod_reg;
    logic                 m1_reg;
    acc_op_t              m1_op_reg;
    logic signed [W-1:0]  addv_reg;
    logic                 ad1_reg;

    logic signed [EW-1:0] rnd, term, accx, sum;
    logic                 sat_term;
    logic signed [D-1:0]  term_d, sum_d;
    always_comb
    begin
        rnd  = EW'(prod_reg) + (EW'(1) <<< (FRAC_BITS - 1));
        term = m1_reg ? (rnd >>> FRAC_BITS) : EW'(addv_reg);
        sat_term = m1_reg && (term > HI || term < LO);
        term_d = (term > HI) ? D'(HI) : ((term < LO) ? D'(LO) : D'(term));
        accx = accw_reg;
        case (m1_op_reg)
            AC_ADD:  sum = accx + EW'(term_d);
            AC_SUB:  sum = accx - EW'(term_d);
            default: sum = EW'(term_d);
        endcase
        sum_d = (sum > HI) ? D'(HI) : ((sum < LO) ? D'(LO) : D'(sum));
    end

    // divider: restoring, one quotient bit per cycle
    logic [NW-1:0]      dq_reg;
    logic [D:0]         drem_reg;
    logic [CW-1:0]      dcnt_reg;
    logic               dneg_reg, dbusy_reg;
    logic [D:0]         dtrial;
    logic [NW:0]        qfin;
    logic signed [NW+1:0] qs;
    logic [D-1:0]       mag;
    logic [NW-1:0]      num0;
    always_comb
    begin
        mag    = op_n[W-1] ? D'(-op_n) : D'(op_n);
        num0   = NW'({mag, FRAC_BITS'(0)}) + NW'(s_reg[D-1:1]);
        dtrial = {drem_reg[D-1:0], dq_reg[NW-1]} - {1'b0, s_reg};
        qfin   = {1'b0, dq_reg};
        qs     = dneg_reg ? -(NW+2)'(qfin) : (NW+2)'(qfin);
    end

    assign stat.mul_busy = m1_reg | ad1_reg;
    assign stat.div_busy = dbusy_reg;
    assign stat.degen    = (s_reg <= 0);

    logic signed [D-1:0] iv;
    assign iv = (VAR_W >= D) ? ((VAR_W'(init_var) > VAR_W'(HI)) ? D'(HI) : D'(init_var))
                             : D'(init_var);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_reg    <= 1'b0;
            ad1_reg   <= 1'b0;
            dbusy_reg <= 1'b0;
            x0_reg    <= '0;
            x1_reg    <= '0;
            p00_reg   <= D'(6553600);
            p01_reg   <= '0;
            p10_reg   <= '0;
            p11_reg   <= D'(6553600);
        end
        else
        begin
            m1_reg  <= cmd.mul_go;
            ad1_reg <= cmd.add_go;
            if (cmd.load && cmd.restart)
            begin
                x0_reg  <= '0;
                x1_reg  <= '0;
                p00_reg <= iv;
                p01_reg <= '0;
                p10_reg <= '0;
                p11_reg <= iv;
            end
            if (cmd.store)
            begin
                case (cmd.dst)
                    RS_X0:   x0_reg  <= acc_reg;
                    RS_X1:   x1_reg  <= acc_reg;
                    RS_P00:  p00_reg <= acc_reg;
                    RS_P01:  p01_reg <= acc_reg;
                    RS_P10:  p10_reg <= acc_reg;
                    RS_P11:  p11_reg <= acc_reg;
                    default: ;
                endcase
            end
            if (cmd.div_go)
                dbusy_reg <= 1'b1;
            else if (dbusy_reg && dcnt_reg == CW'(1))
                dbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= op_a * op_b;
        m1_op_reg <= cmd.op;
        addv_reg  <= op_a;
        if (cmd.load)
        begin
            z_reg     <= measurement;
            sat_reg   <= 1'b0;
            degen_reg <= 1'b0;
        end
        if (m1_reg || ad1_reg)
        begin
            acc_reg  <= sum_d;
            accw_reg <= sum;
            if (sat_term)
                sat_reg <= 1'b1;
        end
        if (cmd.store && (accw_reg > HI || accw_reg < LO))
            sat_reg <= 1'b1;
        if (cmd.chk_s)
            degen_reg <= (acc_reg <= 0);
        if (cmd.store)
        begin
            case (cmd.dst)
                RS_Z:    z_reg   <= acc_reg;
                RS_Y:    y_reg   <= acc_reg;
                RS_PH0:  ph0_reg <= acc_reg;
                RS_PH1:  ph1_reg <= acc_reg;
                RS_S:    s_reg   <= acc_reg;
                RS_HP0:  hp0_reg <= acc_reg;
                RS_HP1:  hp1_reg <= acc_reg;
                RS_A00:  a00_reg <= acc_reg;
                RS_A01:  a01_reg <= acc_reg;
                RS_A10:  a10_reg <= acc_reg;
                RS_A11:  a11_reg <= acc_reg;
                default: ;
            endcase
        end
        if (cmd.div_go)
        begin
            dq_reg   <= num0;
            drem_reg <= '0;
            dcnt_reg <= CW'(NW);
            dneg_reg <= op_n[W-1];
        end
        else if (dbusy_reg)
        begin
            dcnt_reg <= dcnt_reg - CW'(1);
            if (!dtrial[D])
            begin
                drem_reg <= dtrial;
                dq_reg   <= {dq_reg[NW-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= {drem_reg[D-1:0], dq_reg[NW-1]};
                dq_reg   <= {dq_reg[NW-2:0], 1'b0};
            end
        end
        if (cmd.div_store)
        begin
            if (qs > (NW+2)'(HI) || qs < (NW+2)'(LO))
                sat_reg <= 1'b1;
            case (cmd.div_dst)
                RS_K0:   k0_reg <= (qs > (NW+2)'(HI)) ? D'(HI) :
                                   ((qs < (NW+2)'(LO)) ? D'(LO) : D'(qs));
                default: k1_reg <= (qs > (NW+2)'(HI)) ? D'(HI) :
                                   ((qs < (NW+2)'(LO)) ? D'(LO) : D'(qs));
            endcase
        end
        if (cmd.publish)
        begin
            position   <= x0_reg;
            velocity   <= x1_reg;
            cov_00     <= p00_reg;
            cov_01     <= p01_reg;
            cov_10     <= p10_reg;
            cov_11     <= p11_reg;
            degenerate <= degen_reg;
            saturated  <= sat_reg;
        end
    end

endmodule

/* hdl/kft_ctrl.sv */
// Controller: sequences the microprogram of the update and prediction
module kft_ctrl
    import kft_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  restart,
    output logic  out_valid,
    input  logic  out_ready,
    output logic  busy,
    input  stat_t stat,
    output cmd_t  cmd
);
    localparam int PCW   = 6;

    // step kinds
    typedef enum logic [2:0] {
        K_MUL, K_ADD, K_ST, K_CHK, K_DIV, K_END
    } kind_t;

    typedef struct packed {
        kind_t   kind;
        acc_op_t op;
        slot_t   a;
        slot_t   b;
    } step_t;

    function automatic step_t prog(input logic [PCW-1:0] pc);
        step_t s;
        begin
            s = '{K_END, AC_LOAD, RS_ZERO, RS_ZERO};
            case (pc)
                6'd0:  s = '{K_MUL, AC_LOAD, RS_H0, RS_X0};
                6'd1:  s = '{K_MUL, AC_ADD,  RS_H1, RS_X1};
                6'd2:  s = '{K_ST,  AC_LOAD, RS_Y, RS_ZERO};   // hx in y tmp
                6'd3:  s = '{K_ADD, AC_LOAD, RS_Z, RS_ZERO};
                6'd4:  s = '{K_ADD, AC_SUB,  RS_Y, RS_ZERO};
                6'd5:  s = '{K_ST,  AC_LOAD, RS_Y, RS_ZERO};
                6'd6:  s = '{K_MUL, AC_LOAD, RS_P00, RS_H0};
                6'd7:  s = '{K_MUL, AC_ADD,  RS_P01, RS_H1};
                6'd8:  s = '{K_ST,  AC_LOAD, RS_PH0, RS_ZERO};
                6'd9:  s = '{K_MUL, AC_LOAD, RS_P10, RS_H0};
                6'd10: s = '{K_MUL, AC_ADD,  RS_P11, RS_H1};
                6'd11: s = '{K_ST,  AC_LOAD, RS_PH1, RS_ZERO};
                6'd12: s = '{K_MUL, AC_LOAD, RS_H0, RS_PH0};
                6'd13: s = '{K_MUL, AC_ADD,  RS_H1, RS_PH1};
                6'd14: s = '{K_ADD, AC_ADD,  RS_R, RS_ZERO};
                6'd15: s = '{K_ST,  AC_LOAD, RS_S, RS_ZERO};
                6'd16: s = '{K_CHK, AC_LOAD, RS_ZERO, RS_ZERO};
                6'd17: s = '{K_DIV, AC_LOAD, RS_PH0, RS_K0};
                6'd18: s = '{K_DIV, AC_LOAD, RS_PH1, RS_K1};
                6'd19: s = '{K_MUL, AC_LOAD, RS_H0, RS_P00};
                6'd20: s = '{K_MUL, AC_ADD,  RS_H1, RS_P10};
                6'd21: s = '{K_ST,  AC_LOAD, RS_HP0, RS_ZERO};
                6'd22: s = '{K_MUL, AC_LOAD, RS_H0, RS_P01};
                6'd23: s = '{K_MUL, AC_ADD,  RS_H1, RS_P11};
                6'd24: s = '{K_ST,  AC_LOAD, RS_HP1, RS_ZERO};
                6'd25: s = '{K_ADD, AC_LOAD, RS_X0, RS_ZERO};
                6'd26: s = '{K_MUL, AC_ADD,  RS_K0, RS_Y};
                6'd27: s = '{K_ST,  AC_LOAD, RS_X0, RS_ZERO};
                6'd28: s = '{K_ADD, AC_LOAD, RS_X1, RS_ZERO};
                6'd29: s = '{K_MUL, AC_ADD,  RS_K1, RS_Y};
                6'd30: s = '{K_ST,  AC_LOAD, RS_X1, RS_ZERO};
                6'd31: s = '{K_ADD, AC_LOAD, RS_P00, RS_ZERO};
                6'd32: s = '{K_MUL, AC_SUB,  RS_K0, RS_HP0};
                6'd33: s = '{K_ST,  AC_LOAD, RS_P00, RS_ZERO};
                6'd34: s = '{K_ADD, AC_LOAD, RS_P01, RS_ZERO};
                6'd35: s = '{K_MUL, AC_SUB,  RS_K0, RS_HP1};
                6'd36: s = '{K_ST,  AC_LOAD, RS_P01, RS_ZERO};
                6'd37: s = '{K_ADD, AC_LOAD, RS_P10, RS_ZERO};
                6'd38: s = '{K_MUL, AC_SUB,  RS_K1, RS_HP0};
                6'd39: s = '{K_ST,  AC_LOAD, RS_P10, RS_ZERO};
                6'd40: s = '{K_ADD, AC_LOAD, RS_P11, RS_ZERO};
                6'd41: s = '{K_MUL, AC_SUB,  RS_K1, RS_HP1};
                6'd42: s = '{K_ST,  AC_LOAD, RS_P11, RS_ZERO};
                // prediction
                6'd43: s = '{K_MUL, AC_LOAD, RS_F00, RS_P00};
                6'd44: s = '{K_MUL, AC_ADD,  RS_F01, RS_P10};
                6'd45: s = '{K_ST,  AC_LOAD, RS_A00, RS_ZERO};
                6'd46: s = '{K_MUL, AC_LOAD, RS_F00, RS_P01};
                6'd47: s = '{K_MUL, AC_ADD,  RS_F01, RS_P11};
                6'd48: s = '{K_ST,  AC_LOAD, RS_A01, RS_ZERO};
                6'd49: s = '{K_MUL, AC_LOAD, RS_F10, RS_P00};
                6'd50: s = '{K_MUL, AC_ADD,  RS_F11, RS_P10};
                6'd51: s = '{K_ST,  AC_LOAD, RS_A10, RS_ZERO};
                6'd52: s = '{K_MUL, AC_LOAD, RS_F10, RS_P01};
                6'd53: s = '{K_MUL, AC_ADD,  RS_F11, RS_P11};
                6'd54: s = '{K_ST,  AC_LOAD, RS_A11, RS_ZERO};
                6'd55: s = '{K_MUL, AC_LOAD, RS_F00, RS_X0};
                6'd56: s = '{K_MUL, AC_ADD,  RS_F01, RS_X1};
                6'd57: s = '{K_ST,  AC_LOAD, RS_Z, RS_ZERO};   // new x0 parked
                6'd58: s = '{K_MUL, AC_LOAD, RS_F10, RS_X0};
                6'd59: s = '{K_MUL, AC_ADD,  RS_F11, RS_X1};
                6'd60: s = '{K_ST,  AC_LOAD, RS_X1, RS_ZERO};
                default: s = '{K_END, AC_LOAD, RS_ZERO, RS_ZERO};
            endcase
            return s;
        end
    endfunction

    // covariance tail: P_ij = A_i0*f_j0 + A_i1*f_j1, then x0 from the parked value
    function automatic step_t tail(input logic [3:0] t);
        step_t s;
        begin
            case (t)
                4'd0:  s = '{K_MUL, AC_LOAD, RS_A00, RS_F00};
                4'd1:  s = '{K_MUL, AC_ADD,  RS_A01, RS_F01};
                4'd2:  s = '{K_ST,  AC_LOAD, RS_P00, RS_ZERO};
                4'd3:  s = '{K_MUL, AC_LOAD, RS_A00, RS_F10};
                4'd4:  s = '{K_MUL, AC_ADD,  RS_A01, RS_F11};
                4'd5:  s = '{K_ST,  AC_LOAD, RS_P01, RS_ZERO};
                4'd6:  s = '{K_MUL, AC_LOAD, RS_A10, RS_F00};
                4'd7:  s = '{K_MUL, AC_ADD,  RS_A11, RS_F01};
                4'd8:  s = '{K_ST,  AC_LOAD, RS_P10, RS_ZERO};
                4'd9:  s = '{K_MUL, AC_LOAD, RS_A10, RS_F10};
                4'd10: s = '{K_MUL, AC_ADD,  RS_A11, RS_F11};
                4'd11: s = '{K_ST,  AC_LOAD, RS_P11, RS_ZERO};
                4'd12: s = '{K_ADD, AC_LOAD, RS_Z, RS_ZERO};
                4'd13: s = '{K_ST,  AC_LOAD, RS_X0, RS_ZERO};
                default: s = '{K_END, AC_LOAD, RS_ZERO, RS_ZERO};
            endcase
            return s;
        end
    endfunction

    state_t          state_reg, state_next;
    logic [PCW-1:0]  pc_reg, pc_next;
    logic [3:0]      tp_reg, tp_next;
    logic            tl_reg, tl_next;
    step_t           st;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            tp_reg    <= '0;
            tl_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            tp_reg    <= tp_next;
            tl_reg    <= tl_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        tp_next    = tp_reg;
        tl_next    = tl_reg;
        cmd        = '0;
        cmd.mul_a  = RS_ZERO;
        cmd.mul_b  = RS_ZERO;
        cmd.dst    = RS_ZERO;
        cmd.div_num = RS_ZERO;
        cmd.div_dst = RS_K0;
        cmd.op     = AC_LOAD;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        st         = tl_reg ? tail(tp_reg) : prog(pc_reg);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load    = 1'b1;
                    cmd.restart = restart;
                    pc_next     = '0;
                    tp_next     = '0;
                    tl_next     = 1'b0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN:
            begin
                case (st.kind)
                    K_MUL, K_ADD:
                    begin
                        cmd.mul_go = (st.kind == K_MUL);
                        cmd.add_go = (st.kind == K_ADD);
                        cmd.mul_a  = st.a;
                        cmd.mul_b  = st.b;
                        cmd.op     = st.op;
                        state_next = ST_WAIT;
                    end
                    K_ST:
                    begin
                        cmd.store = 1'b1;
                        cmd.dst   = st.a;
                    end
                    K_CHK:
                    begin
                        cmd.chk_s = 1'b1;
                    end
                    K_DIV:
                    begin
                        cmd.div_go  = 1'b1;
                        cmd.div_num = st.a;
                        state_next  = ST_DIV;
                    end
                    default:
                    begin
                        if (tl_reg)
                        begin
                            state_next = ST_OUT;
                            cmd.publish = 1'b1;
                        end
                        else
                        begin
                            tl_next = 1'b1;
                            tp_next = '0;
                        end
                    end
                endcase
                if (st.kind == K_ST || st.kind == K_CHK)
                begin
                    if (tl_reg)
                        tp_next = tp_reg + 4'd1;
                    else if (st.kind == K_CHK && stat.degen)
                        pc_next = 6'd43;
                    else if (st.kind == K_ST && st.a == RS_Z)
                        pc_next = pc_reg + 6'd1;
                    else
                        pc_next = pc_reg + 6'd1;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_RUN;
                if (tl_reg)
                    tp_next = tp_reg + 4'd1;
                else
                    pc_next = pc_reg + 6'd1;
            end
            ST_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.div_store = 1'b1;
                    cmd.div_dst   = st.b;
                    pc_next       = pc_reg + 6'd1;
                    state_next    = ST_RUN;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
        busy = (state_reg != ST_IDLE);
    end

endmodule

/* hdl/kalman_filter_two_state.sv */
// From input transaction to result valid the controller runs MAC steps, store/check steps,
// two serial divisions and two end-of-program steps; the update part is skipped when
// S is not positive. One item at a time.
// The result register holds until taken; the next item can be accepted in the following cycle.
// Reset (async, active low): registers to defaults, state zero, covariance diag(100).
module kalman_filter_two_state
    import kft_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_W_DEF,
    parameter int FRAC_BITS  = FRAC_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] measurement,
    input  logic                         restart,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] position,
    output logic signed [DATA_WIDTH-1:0] velocity,
    output logic signed [DATA_WIDTH-1:0] cov_00,
    output logic signed [DATA_WIDTH-1:0] cov_01,
    output logic signed [DATA_WIDTH-1:0] cov_10,
    output logic signed [DATA_WIDTH-1:0] cov_11,
    output logic                         degenerate,
    output logic                         saturated,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [IDX_W-1:0]             cfg_index,
    input  logic [REG_W-1:0]             cfg_data
);
    logic signed [REG_W-1:0] t00_reg, t01_reg, t10_reg, t11_reg, h0_reg, h1_reg;
    logic [VAR_W-1:0]        r_reg, iv_reg;
    cmd_t                    cmd;
    stat_t                   stat;
    logic                    busy;

    assign cfg_ready = !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t00_reg <= 32'sd65536;
            t01_reg <= 32'sd65536;
            t10_reg <= '0;
            t11_reg <= 32'sd65536;
            h0_reg  <= 32'sd65536;
            h1_reg  <= '0;
            r_reg   <= 31'd65536;
            iv_reg  <= 31'd6553600;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                IDX_T00:  t00_reg <= cfg_data;
                IDX_T01:  t01_reg <= cfg_data;
                IDX_T10:  t10_reg <= cfg_data;
                IDX_T11:  t11_reg <= cfg_data;
                IDX_H0:   h0_reg  <= cfg_data;
                IDX_H1:   h1_reg  <= cfg_data;
                IDX_R:    r_reg   <= cfg_data[VAR_W-1:0];
                IDX_INIT: iv_reg  <= cfg_data[VAR_W-1:0];
                default:  ;
            endcase
        end
    end

    kft_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .busy      (busy),
        .stat      (stat),
        .cmd       (cmd)
    );

    kft_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .measurement (measurement),
        .f00         (t00_reg),
        .f01         (t01_reg),
        .f10         (t10_reg),
        .f11         (t11_reg),
        .h0          (h0_reg),
        .h1          (h1_reg),
        .r_var       (r_reg),
        .init_var    (iv_reg),
        .position    (position),
        .velocity    (velocity),
        .cov_00      (cov_00),
        .cov_01      (cov_01),
        .cov_10      (cov_10),
        .cov_11      (cov_11),
        .degenerate  (degenerate),
        .saturated   (saturated)
    );

endmodule

/* tb/tb_kalman_filter_two_state.sv */
// Testbench for kalman_filter_two_state: fixed-point filter predictor with directed and random stimulus.
module tb_kalman_filter_two_state
    import kft_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = 32;
    localparam int FB = 16;
    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    typedef struct {
        logic signed [DW-1:0] position, velocity, cov_00, cov_01, cov_10, cov_11;
        logic degenerate, saturated;
    } estimate_t;

    class estimate_board;
        longint f00, f01, f10, f11, h0, h1, noise, init_var;
        longint x0, x1, p00, p01, p10, p11;
        bit clipped;
        estimate_t pending[$];
        int errors;

        function void reset_state();
            f00 = 65536; f01 = 65536; f10 = 0; f11 = 65536;
            h0 = 65536; h1 = 0; noise = 65536; init_var = 6553600;
            x0 = 0; x1 = 0; p00 = init_var; p01 = 0; p10 = 0; p11 = init_var;
            errors = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] v);
            case (idx)
                IDX_T00:  f00 = longint'($signed(v));
                IDX_T01:  f01 = longint'($signed(v));
                IDX_T10:  f10 = longint'($signed(v));
                IDX_T11:  f11 = longint'($signed(v));
                IDX_H0:   h0 = longint'($signed(v));
                IDX_H1:   h1 = longint'($signed(v));
                IDX_R:    noise = longint'({33'd0, v[30:0]});
                IDX_INIT: init_var = longint'({33'd0, v[30:0]});
                default: ;
            endcase
        endfunction

        function longint clip(longint v);
            if (v > SAT_HI) begin clipped = 1; return SAT_HI; end
            if (v < SAT_LO) begin clipped = 1; return SAT_LO; end
            return v;
        endfunction

        function longint qmul(longint a, longint b);
            return clip((a * b + (64'sd1 <<< (FB - 1))) >>> FB);
        endfunction

        function longint qdiv(longint a, longint s);
            longint m, q;
            m = (a < 0) ? -a : a;
            q = ((m <<< FB) + (s >>> 1)) / s;
            return clip(a < 0 ? -q : q);
        endfunction

        function void note_measurement(logic signed [DW-1:0] z_in, logic rst_bit);
            longint z, hx, y, ph0, ph1, s, k0, k1, hp0, hp1, a00, a01, a10, a11;
            estimate_t e;
            z = z_in;
            clipped = 0;
            e.degenerate = 0;
            if (rst_bit) begin
                x0 = 0; x1 = 0; p00 = clip(init_var); p01 = 0; p10 = 0; p11 = clip(init_var);
            end
            hx = clip(qmul(h0, x0) + qmul(h1, x1));
            y = clip(z - hx);
            ph0 = clip(qmul(p00, h0) + qmul(p01, h1));
            ph1 = clip(qmul(p10, h0) + qmul(p11, h1));
            s = clip(qmul(h0, ph0) + qmul(h1, ph1) + noise);
            if (s <= 0) e.degenerate = 1;
            else begin
                k0 = qdiv(ph0, s); k1 = qdiv(ph1, s);
                hp0 = clip(qmul(h0, p00) + qmul(h1, p10));
                hp1 = clip(qmul(h0, p01) + qmul(h1, p11));
                x0 = clip(x0 + qmul(k0, y));
                x1 = clip(x1 + qmul(k1, y));
                p00 = clip(p00 - qmul(k0, hp0));
                p01 = clip(p01 - qmul(k0, hp1));
                p10 = clip(p10 - qmul(k1, hp0));
                p11 = clip(p11 - qmul(k1, hp1));
            end
            hx = clip(qmul(f00, x0) + qmul(f01, x1));
            x1 = clip(qmul(f10, x0) + qmul(f11, x1));
            x0 = hx;
            a00 = clip(qmul(f00, p00) + qmul(f01, p10));
            a01 = clip(qmul(f00, p01) + qmul(f01, p11));
            a10 = clip(qmul(f10, p00) + qmul(f11, p10));
            a11 = clip(qmul(f10, p01) + qmul(f11, p11));
            p00 = clip(qmul(a00, f00) + qmul(a01, f01));
            p01 = clip(qmul(a00, f10) + qmul(a01, f11));
            p10 = clip(qmul(a10, f00) + qmul(a11, f01));
            p11 = clip(qmul(a10, f10) + qmul(a11, f11));
            e.position = x0[DW-1:0]; e.velocity = x1[DW-1:0];
            e.cov_00 = p00[DW-1:0]; e.cov_01 = p01[DW-1:0];
            e.cov_10 = p10[DW-1:0]; e.cov_11 = p11[DW-1:0];
            e.saturated = clipped;
            pending.push_back(e);
        endfunction

        function void report(string f, longint ex, longint ac);
            $display("%0t: %s expected %0h actual %0h", $time, f, ex, ac);
            errors++;
        endfunction

        function void check_estimate(estimate_t a);
            estimate_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected transaction, position %0h", $time, a.position);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.position !== e.position) report("position", e.position, a.position);
            if (a.velocity !== e.velocity) report("velocity", e.velocity, a.velocity);
            if (a.cov_00 !== e.cov_00) report("cov_00", e.cov_00, a.cov_00);
            if (a.cov_01 !== e.cov_01) report("cov_01", e.cov_01, a.cov_01);
            if (a.cov_10 !== e.cov_10) report("cov_10", e.cov_10, a.cov_10);
            if (a.cov_11 !== e.cov_11) report("cov_11", e.cov_11, a.cov_11);
            if (a.degenerate !== e.degenerate) report("degenerate", e.degenerate, a.degenerate);
            if (a.saturated !== e.saturated) report("saturated", e.saturated, a.saturated);
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic in_valid = 0, in_ready, restart = 0;
    logic signed [DW-1:0] measurement = 0;
    logic out_valid, out_ready = 0;
    logic signed [DW-1:0] position, velocity, cov_00, cov_01, cov_10, cov_11;
    logic degenerate, saturated;
    logic cfg_valid = 0, cfg_ready;
    logic [IDX_W-1:0] cfg_index = 0;
    logic [REG_W-1:0] cfg_data = 0;

    int send_idle = 0, recv_stall = 0, hold_off = 0;
    longint cycles = 0;
    estimate_board board;

    kalman_filter_two_state dut (.*);

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2_000_000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver with random stalls and an optional long hold-off
    always @(posedge clk)
    begin
        estimate_t a;
        if (rst_n && out_valid && out_ready)
        begin
            a.position = position; a.velocity = velocity;
            a.cov_00 = cov_00; a.cov_01 = cov_01; a.cov_10 = cov_10; a.cov_11 = cov_11;
            a.degenerate = degenerate; a.saturated = saturated;
            board.check_estimate(a);
        end
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            out_ready <= 0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall);
    end

    // valid stays high between back-to-back transactions; drain() drops it
    task automatic send(logic signed [DW-1:0] z, logic r);
        if (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            do @(posedge clk); while ($urandom_range(99) < send_idle);
        end
        in_valid <= 1; measurement <= z; restart <= r;
        do @(posedge clk); while (!in_ready);
        board.note_measurement(z, r);
    endtask

    task automatic write_cfg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] v);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= v;
        do @(posedge clk); while (!cfg_ready);
        board.write_reg(idx, v);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic signed [DW-1:0] rand_meas();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(0, 2 * 65536 * 50)) - 65536 * 50;
            2: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 65536 * 8)) - 65536 * 4;
        endcase
    endfunction

    task automatic random_run(int n, int si, int rs);
        send_idle = si; recv_stall = rs;
        repeat (n) send(rand_meas(), $urandom_range(15) == 0);
        drain();
    endtask

    function automatic logic [REG_W-1:0] rand_q(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    initial
    begin
        board = new();
        board.reset_state();
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, restart, degenerate innovation variance
        send(0, 0); send(32'sh7fffffff, 0); send(32'sh80000000, 0);
        send(65536, 1); send(-65536, 0); send(32'sh7fffffff, 1);
        send($urandom, 0); send(32'sh80000000, 1);
        drain();
        write_cfg(IDX_R, 0); write_cfg(IDX_INIT, 0);
        send(65536, 1); send(3 * 65536, 0);
        drain();
        write_cfg(IDX_H0, 0); write_cfg(IDX_H1, 0); write_cfg(IDX_R, 0);
        send(12345, 0); send(-12345, 1);
        drain();
        write_cfg(IDX_H0, 32'h7fffffff); write_cfg(IDX_H1, 32'h80000000);
        write_cfg(IDX_R, 32'h7fffffff); write_cfg(IDX_INIT, 32'h7fffffff);
        write_cfg(IDX_T00, 32'h80000000); write_cfg(IDX_T01, 32'h7fffffff);
        write_cfg(IDX_T10, 32'h7fffffff); write_cfg(IDX_T11, 32'h80000000);
        send(32'sh7fffffff, 1); send(32'sh80000000, 0); send(0, 0);
        drain();
        write_cfg(IDX_T00, 32'hffff0000); write_cfg(IDX_H0, 32'hffff0000);
        write_cfg(IDX_H1, 32'h00010000); write_cfg(IDX_R, 32'hffffffff);
        send(65536, 1); send(-65536, 0);
        drain();

        // nominal constant-velocity settings
        write_cfg(IDX_T00, 65536); write_cfg(IDX_T01, 65536);
        write_cfg(IDX_T10, 0); write_cfg(IDX_T11, 65536);
        write_cfg(IDX_H0, 65536); write_cfg(IDX_H1, 0);
        write_cfg(IDX_R, 65536); write_cfg(IDX_INIT, 6553600);
        random_run(150, 0, 0);

        write_cfg(IDX_T01, 6554); write_cfg(IDX_R, 4 * 65536);
        random_run(150, 74, 0);

        hold_off = 3000;
        random_run(20, 0, 0);

        write_cfg(IDX_T00, rand_q(80000)); write_cfg(IDX_T01, rand_q(80000));
        write_cfg(IDX_T10, rand_q(30000)); write_cfg(IDX_T11, rand_q(80000));
        write_cfg(IDX_H0, rand_q(80000)); write_cfg(IDX_H1, rand_q(80000));
        write_cfg(IDX_R, $urandom_range(0, 200000)); write_cfg(IDX_INIT, $urandom);
        random_run(150, 0, 74);

        write_cfg(IDX_T00, $urandom); write_cfg(IDX_T01, $urandom);
        write_cfg(IDX_T10, $urandom); write_cfg(IDX_T11, $urandom);
        write_cfg(IDX_H0, $urandom); write_cfg(IDX_H1, $urandom);
        write_cfg(IDX_R, $urandom); write_cfg(IDX_INIT, $urandom);
        random_run(150, 38, 38);

        if (board.errors == 0 && board.pending.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

/* filelist.f */
hdl/kft_pkg.sv
hdl/kft_datapath.sv
hdl/kft_ctrl.sv
hdl/kalman_filter_two_state.sv
tb/tb_kalman_filter_two_state.sv
